/* sv/rbcd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the RSSI baseline change detector.
// No dependencies; used by every module of the block.
package rbcd_pkg;

  localparam int DEVICE_SLOTS_DEF = 64;

  localparam int ADDR_W  = 32;
  localparam int LEVEL_W = 13;
  localparam int STAMP_W = 64;
  localparam int FRAC_W  = 17;
  localparam int EXCESS_W = 14;
  localparam int STATUS_W = 8;

  localparam logic [STATUS_W-1:0] STATUS_ACCEPT = 8'd16;
  localparam logic [FRAC_W-1:0]   FRAC_ONE      = 17'd65536;
  localparam logic [FRAC_W-1:0]   FRAC_RESET    = 17'd6554;

  // One record as it travels down the slot chain
  typedef struct packed {
    logic                       valid;
    logic                       found;   // matched a stored device
    logic                       placed;  // stored as a new device
    logic [ADDR_W-1:0]          addr;
    logic signed [LEVEL_W-1:0]  rssi;
    logic [STAMP_W-1:0]         stamp;
    logic signed [LEVEL_W-1:0]  base;
  } query_t;

endpackage

/* sv/rbcd_cell.sv */
`timescale 1ns / 1ps
// One device slot of the chain: holds an address and its base level,
// matches or claims the passing request, and hands it to the next slot.
// Depends on rbcd_pkg.
module rbcd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  rbcd_pkg::query_t q_in,
  output rbcd_pkg::query_t q_out,
  output logic            occupied
);
  import rbcd_pkg::*;

  logic                      slot_valid;
  logic [ADDR_W-1:0]         slot_address;
  logic signed [LEVEL_W-1:0] slot_base;

  query_t q_next;
  logic   claim;

  // Match against the stored device, or claim this slot if it is free
  always_comb begin
    q_next = q_in;
    claim  = 1'b0;
    if (q_in.valid && !q_in.found && !q_in.placed) begin
      if (slot_valid && slot_address == q_in.addr) begin
        q_next.found = 1'b1;
        q_next.base  = slot_base;
      end else if (!slot_valid) begin
        q_next.placed = 1'b1;
        claim         = 1'b1;
      end
    end
  end

  // Advance the request and update the slot; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
      slot_valid  <= 1'b0;
    end else if (adv) begin
      q_out.valid <= q_next.valid;
      if (claim) begin
        slot_valid <= 1'b1;
      end
    end
    if (adv) begin
      q_out.found  <= q_next.found;
      q_out.placed <= q_next.placed;
      q_out.addr   <= q_next.addr;
      q_out.rssi   <= q_next.rssi;
      q_out.stamp  <= q_next.stamp;
      q_out.base   <= q_next.base;
      if (claim) begin
        slot_address <= q_in.addr;
        slot_base    <= q_in.rssi;
      end
    end
  end

  assign occupied = slot_valid;

endmodule

/* sv/rbcd_check.sv */
`timescale 1ns / 1ps
// Band check behind the slot chain: margin multiply stage, then the
// band compare and excess into the output register. Depends on rbcd_pkg.
module rbcd_check (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic [rbcd_pkg::FRAC_W-1:0]        frac,
  input  rbcd_pkg::query_t                   q_tail,
  output logic                               alert_valid,
  output logic [rbcd_pkg::ADDR_W-1:0]        alert_address,
  output logic [rbcd_pkg::STAMP_W-1:0]       alert_time,
  output logic signed [rbcd_pkg::LEVEL_W-1:0] base_level,
  output logic signed [rbcd_pkg::LEVEL_W-1:0] measured_level,
  output logic [rbcd_pkg::EXCESS_W-1:0]      excess
);
  import rbcd_pkg::*;

  localparam int PROD_W = 31;
  localparam int BAND_W = 15;

  // Margin stage
  logic [FRAC_W-1:0]          frac_sat;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   rounded;
  logic                       m_valid;
  logic [ADDR_W-1:0]          m_addr;
  logic [STAMP_W-1:0]         m_stamp;
  logic signed [LEVEL_W-1:0]  m_base;
  logic signed [LEVEL_W-1:0]  m_rssi;
  logic signed [EXCESS_W-1:0] m_margin;

  // Compare stage
  logic signed [BAND_W-1:0] base_x;
  logic signed [BAND_W-1:0] rssi_x;
  logic signed [BAND_W-1:0] hi;
  logic signed [BAND_W-1:0] lo;
  logic signed [BAND_W-1:0] ex;
  logic                     in_band;

  // Clamp the fraction at 1.0 and scale the base, rounding halves up
  always_comb begin
    frac_sat = (frac > FRAC_ONE) ? FRAC_ONE : frac;
    prod     = PROD_W'(q_tail.base) * PROD_W'(signed'({1'b0, frac_sat}));
    rounded  = prod + PROD_W'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= q_tail.valid && q_tail.found;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_addr   <= q_tail.addr;
      m_stamp  <= q_tail.stamp;
      m_base   <= q_tail.base;
      m_rssi   <= q_tail.rssi;
      m_margin <= EXCESS_W'(rounded >>> 16);
    end
  end

  // Band edges and distance beyond the violated edge
  always_comb begin
    base_x  = BAND_W'(m_base);
    rssi_x  = BAND_W'(m_rssi);
    hi      = base_x + BAND_W'(m_margin);
    lo      = base_x - BAND_W'(m_margin);
    in_band = (hi <= rssi_x) && (rssi_x <= lo);
    ex      = (hi > rssi_x) ? (hi - rssi_x) : (rssi_x - lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alert_valid <= 1'b0;
    end else if (adv) begin
      alert_valid <= m_valid && !in_band;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alert_address  <= m_addr;
      alert_time     <= m_stamp;
      base_level     <= m_base;
      measured_level <= m_rssi;
      excess         <= ex[EXCESS_W-1:0];
    end
  end

endmodule

/* sv/rssi_baseline_change_detector.sv */
`timescale 1ns / 1ps
// RSSI baseline change detector, top level.
// Input records (status, device_address, rssi_in, time_stamp) enter on
// in_valid/in_ready; alerts leave on out_valid/out_ready. The user must
// write the variance fraction through cfg_write/cfg_data only while
// idle; the block does not enforce this. Each record walks a chain of
// DEVICE_SLOTS slot cells, one cell per cycle while the chain advances,
// then a margin multiply stage and the band compare stage that loads
// the output register. One record is accepted every cycle unless an
// alert waits with out_ready low. Records with a status other than 16
// enter as bubbles and produce nothing. Unknown devices claim the first
// free cell on the way; when all cells are taken they pass through and
// are dropped. Records from known devices that stay in band produce no
// alert. When an alert waits with out_ready low, the whole chain and
// in_ready hold until it is taken. Reset empties all slots and the
// pipeline and sets the fraction to 6554 (about 0.1); no clearing pass
// is needed. Depends on rbcd_pkg, rbcd_cell and rbcd_check.
module rssi_baseline_change_detector #(
  parameter int DEVICE_SLOTS = rbcd_pkg::DEVICE_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rbcd_pkg::STATUS_W-1:0]       status,
  input  logic [rbcd_pkg::ADDR_W-1:0]         device_address,
  input  logic signed [rbcd_pkg::LEVEL_W-1:0] rssi_in,
  input  logic [rbcd_pkg::STAMP_W-1:0]        time_stamp,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rbcd_pkg::ADDR_W-1:0]         alert_address,
  output logic [rbcd_pkg::STAMP_W-1:0]        alert_time,
  output logic signed [rbcd_pkg::LEVEL_W-1:0] base_level,
  output logic signed [rbcd_pkg::LEVEL_W-1:0] measured_level,
  output logic [rbcd_pkg::EXCESS_W-1:0]       excess,
  input  logic                                cfg_write,
  input  logic [rbcd_pkg::FRAC_W-1:0]         cfg_data
);
  import rbcd_pkg::*;

  logic                    adv;
  logic [FRAC_W-1:0]       variance_frac;
  query_t                  q [DEVICE_SLOTS+1];
  logic [DEVICE_SLOTS-1:0] occupied;

  // Advance everything whenever the output register is free or drains
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Hold the variance fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      variance_frac <= FRAC_RESET;
    end else if (cfg_write) begin
      variance_frac <= cfg_data;
    end
  end

  // Build the request entering the chain; drop other status codes
  assign q[0] = '{valid:  in_valid && in_ready && (status == STATUS_ACCEPT),
                  found:  1'b0,
                  placed: 1'b0,
                  addr:   device_address,
                  rssi:   rssi_in,
                  stamp:  time_stamp,
                  base:   rssi_in};

  // Chain of slot cells
  for (genvar i = 0; i < DEVICE_SLOTS; i++) begin : g_slot
    rbcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .q_in     (q[i]),
      .q_out    (q[i+1]),
      .occupied (occupied[i])
    );
  end

  rbcd_check u_check (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .frac           (variance_frac),
    .q_tail         (q[DEVICE_SLOTS]),
    .alert_valid    (out_valid),
    .alert_address  (alert_address),
    .alert_time     (alert_time),
    .base_level     (base_level),
    .measured_level (measured_level),
    .excess         (excess)
  );

`ifndef NO_ASSERTIONS
  // Slots fill in order: a taken slot never follows a free one
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    ((occupied >> 1) & ~occupied) == '0)
    else $error("slot chain has a gap");

  // An alert always lies strictly outside the band
  a_excess_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> excess != '0)
    else $error("alert with zero excess");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("alert present right after reset");

  // A stalled alert keeps its content
  a_alert_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(excess) && $stable(alert_address))
    else $error("stalled alert changed");
`endif

endmodule

/* dv/rssi_baseline_change_detector_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rssi_baseline_change_detector: a directed table, then
// randomized device traffic over several variance settings, checked against a local predictor.
// Depends on rbcd_pkg and the detector RTL only.
module rssi_baseline_change_detector_test;
  import rbcd_pkg::*;

  localparam int SLOTS          = 64;
  localparam int DRAIN_CYCLES   = 2 * (SLOTS + 2) + 20;
  localparam int PHASE_RECORDS  = 55;
  localparam int PRESSURE_AFTER = 12;
  localparam int PRESSURE_HOLD  = 400;
  localparam int CYCLE_LIMIT    = 400000;

  typedef enum logic [1:0] {WANT_PREDICTED, WANT_NONE, WANT_ALERT} want_t;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [ADDR_W-1:0]         addr;
    logic [STAMP_W-1:0]        stamp;
    logic signed [LEVEL_W-1:0] base;
    logic signed [LEVEL_W-1:0] level;
    logic [EXCESS_W-1:0]       over_edge;
  } alert_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       st;
    logic [ADDR_W-1:0]         addr;
    logic signed [LEVEL_W-1:0] rssi;
    logic [STAMP_W-1:0]        stamp;
    want_t                     want;
    logic signed [LEVEL_W-1:0] base;
    logic [EXCESS_W-1:0]       over_edge;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [STATUS_W-1:0]        status = '0;
  logic [ADDR_W-1:0]          device_address = '0;
  logic signed [LEVEL_W-1:0]  rssi_in = '0;
  logic [STAMP_W-1:0]         time_stamp = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ADDR_W-1:0]          alert_address;
  logic [STAMP_W-1:0]         alert_time;
  logic signed [LEVEL_W-1:0]  base_level;
  logic signed [LEVEL_W-1:0]  measured_level;
  logic [EXCESS_W-1:0]        excess;
  logic                       cfg_write = 1'b0;
  logic [FRAC_W-1:0]          cfg_data = '0;

  // Predictor state: device table and the current variance setting
  logic [ADDR_W-1:0]          known_addr [SLOTS];
  logic signed [LEVEL_W-1:0]  known_base [SLOTS];
  int                         devices_stored = 0;
  logic [FRAC_W-1:0]          variance_setting = FRAC_RESET;

  alert_t    pending_alerts[$];
  stim_row_t directed_rows[$];

  int        errors = 0;
  int        alerts_seen = 0;
  int        processed_records = 0;
  int        ignored_records = 0;
  int        cycle_count = 0;
  int        burst_left = 0;

  int        hold_left = 0;
  bit        pressure_done = 1'b0;
  rx_mode_t  ready_mode = RX_FREE;
  int        mode_left = 0;

  rssi_baseline_change_detector #(.DEVICE_SLOTS(SLOTS)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .status         (status),
    .device_address (device_address),
    .rssi_in        (rssi_in),
    .time_stamp     (time_stamp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .alert_address  (alert_address),
    .alert_time     (alert_time),
    .base_level     (base_level),
    .measured_level (measured_level),
    .excess         (excess),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d alerts still owed", cycle_count,
               pending_alerts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Fraction as the block applies it: anything above 1.0 saturates
  function automatic int applied_frac();
    return (variance_setting > FRAC_ONE) ? int'(FRAC_ONE) : int'(variance_setting);
  endfunction

  function automatic int find_slot(input logic [ADDR_W-1:0] a);
    int hit;
    hit = -1;
    for (int i = 0; i < devices_stored && hit < 0; i++)
      if (known_addr[i] == a) hit = i;
    return hit;
  endfunction

  // Track the device table and tell whether this record raises an alert
  function automatic bit predict_alert(input logic [STATUS_W-1:0] st,
                                       input logic [ADDR_W-1:0] a,
                                       input logic signed [LEVEL_W-1:0] r,
                                       input logic [STAMP_W-1:0] ts,
                                       output alert_t al);
    int     slot;
    int     b;
    int     lvl;
    int     margin;
    int     hi;
    int     lo;
    longint prod;
    al = '0;
    if (st != STATUS_ACCEPT) return 1'b0;
    slot = find_slot(a);
    lvl = r;
    if (slot < 0) begin
      // new device: claim the next slot, drop it when the table is full
      if (devices_stored < SLOTS) begin
        known_addr[devices_stored] = a;
        known_base[devices_stored] = r;
        devices_stored++;
      end
      return 1'b0;
    end
    b = known_base[slot];
    prod = longint'(b) * longint'(applied_frac());
    margin = int'((prod + 64'sd32768) >>> 16);
    hi = b + margin;
    lo = b - margin;
    if (hi <= lvl && lvl <= lo) return 1'b0;
    al.addr = a;
    al.stamp = ts;
    al.base = known_base[slot];
    al.level = r;
    al.over_edge = (hi > lvl) ? EXCESS_W'(hi - lvl) : EXCESS_W'(lvl - lo);
    return 1'b1;
  endfunction

  // Idle the sender between bursts of random length
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one request, hold it until taken, then queue what it should cause
  task automatic send_record(input stim_row_t row);
    alert_t al;
    bit     hit;
    in_valid       <= 1'b1;
    status         <= row.st;
    device_address <= row.addr;
    rssi_in        <= row.rssi;
    time_stamp     <= row.stamp;
    do @(posedge clk); while (!in_ready);
    hit = predict_alert(row.st, row.addr, row.rssi, row.stamp, al);
    if (row.want == WANT_NONE) begin
      hit = 1'b0;
    end else if (row.want == WANT_ALERT) begin
      hit = 1'b1;
      al = '{addr: row.addr, stamp: row.stamp, base: row.base, level: row.rssi,
             over_edge: row.over_edge};
    end
    if (hit) pending_alerts.push_back(al);
    if (row.st == STATUS_ACCEPT) processed_records++;
    else ignored_records++;
    pace_sender();
  endtask

  // Drop valid, wait out every owed alert and the pipeline behind it
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_alerts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fraction(input logic [FRAC_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    variance_setting = value;
  endtask

  task automatic add_row(input logic [STATUS_W-1:0] st, input logic [ADDR_W-1:0] a,
                         input int lvl, input logic [STAMP_W-1:0] ts, input want_t want,
                         input int b, input int over);
    directed_rows.push_back(stim_row_t'{st: st, addr: a, rssi: LEVEL_W'(lvl), stamp: ts,
                                        want: want, base: LEVEL_W'(b),
                                        over_edge: EXCESS_W'(over)});
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Receiver: random ready pattern, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && alerts_seen >= PRESSURE_AFTER) begin
      pressure_done <= 1'b1;
      hold_left <= PRESSURE_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RX_FREE:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ready <= (mode_left[2:0] != 3'd0);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  // Check each taken alert against the oldest owed one
  always @(posedge clk) begin
    alert_t want;
    if (!rst && out_valid && out_ready) begin
      alerts_seen <= alerts_seen + 1;
      if (pending_alerts.size() == 0) begin
        errors++;
        $display("%0t: unexpected alert, expected none, actual address %0h level %0d",
                 $time, alert_address, measured_level);
      end else begin
        want = pending_alerts.pop_front();
        check_field("alert_address", want.addr, alert_address);
        check_field("alert_time", want.stamp, alert_time);
        check_field("base_level", want.base, base_level);
        check_field("measured_level", want.level, measured_level);
        check_field("excess", want.over_edge, excess);
      end
    end
  end

  initial begin
    logic [FRAC_W-1:0]   settings [6];
    logic [ADDR_W-1:0]   address_pool[$];
    logic [STATUS_W-1:0] st;
    logic [ADDR_W-1:0]   a;
    int                  slot;
    int                  b;
    int                  spread;
    int                  lvl;
    int                  count;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset fraction (about 0.1)
    add_row(8'd0,   32'h0, 0, 64'h0, WANT_NONE, 0, 0);
    add_row(8'd255, 32'hFFFF_FFFF, -1, '1, WANT_NONE, 0, 0);
    add_row(8'd17,  32'h0, 0, 64'h0, WANT_NONE, 0, 0);
    add_row(8'd15,  32'h0, 0, 64'h0, WANT_NONE, 0, 0);
    // lowest level: stored as base, then in band, then the far edge
    add_row(STATUS_ACCEPT, 32'h0, -4096, 64'h0, WANT_NONE, 0, 0);
    add_row(STATUS_ACCEPT, 32'h0, -4096, 64'h1, WANT_NONE, 0, 0);
    add_row(STATUS_ACCEPT, 32'h0, 4095, '1, WANT_ALERT, -4096, 7781);
    // positive base always alerts
    add_row(STATUS_ACCEPT, 32'hFFFF_FFFF, 4095, 64'h2, WANT_NONE, 0, 0);
    add_row(STATUS_ACCEPT, 32'hFFFF_FFFF, 4095, 64'h3, WANT_ALERT, 4095, 410);
    add_row(STATUS_ACCEPT, 32'hFFFF_FFFF, -4096, 64'h4, WANT_ALERT, 4095, 8601);
    // zero base: empty margin, any change alerts
    add_row(STATUS_ACCEPT, 32'h1, 0, 64'h5, WANT_NONE, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1, 0, 64'h6, WANT_NONE, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1, 1, 64'h7, WANT_ALERT, 0, 1);
    add_row(STATUS_ACCEPT, 32'h1, -1, 64'h8, WANT_ALERT, 0, 1);
    // typical base with band edges on both sides
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1600, 64'h9, WANT_NONE, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1500, 64'hA, WANT_PREDICTED, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1400, 64'hB, WANT_PREDICTED, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1800, 64'hC, WANT_PREDICTED, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1760, 64'hD, WANT_PREDICTED, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1761, 64'hE, WANT_PREDICTED, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1440, 64'hF, WANT_PREDICTED, 0, 0);
    add_row(STATUS_ACCEPT, 32'h1234_5678, -1439, 64'h10, WANT_PREDICTED, 0, 0);
    add_row(8'd144, 32'h1234_5678, 4095, 64'h11, WANT_NONE, 0, 0);
    foreach (directed_rows[i]) send_record(directed_rows[i]);
    address_pool.push_back(32'h0);
    address_pool.push_back(32'hFFFF_FFFF);
    address_pool.push_back(32'h1);
    address_pool.push_back(32'h1234_5678);

    // Random traffic, one phase per variance setting
    settings[0] = '0;
    settings[1] = FRAC_ONE;
    settings[2] = '1;
    settings[3] = FRAC_W'($urandom_range(1, 65535));
    settings[4] = 17'd32768;
    settings[5] = FRAC_RESET;
    foreach (settings[p]) begin
      settle();
      write_fraction(settings[p]);
      count = 0;
      while (count < PHASE_RECORDS) begin
        st = ($urandom_range(0, 99) < 85) ? STATUS_ACCEPT : STATUS_W'($urandom_range(0, 255));
        // mostly revisit seen devices, sometimes a new one
        if ($urandom_range(0, 3) == 0) begin
          a = $urandom;
          address_pool.push_back(a);
        end else begin
          a = address_pool[$urandom_range(0, address_pool.size() - 1)];
        end
        slot = find_slot(a);
        if (slot >= 0 && $urandom_range(0, 4) != 0) begin
          // land near the band edges of a tracked device
          b = known_base[slot];
          spread = (((b < 0) ? -b : b) * applied_frac() >>> 16) + 4;
          lvl = b + int'($urandom_range(0, 2 * spread)) - spread;
          if (lvl > 4095) lvl = 4095;
          if (lvl < -4096) lvl = -4096;
        end else if ($urandom_range(0, 1) == 1) begin
          lvl = -int'($urandom_range(320, 2400));
        end else begin
          lvl = int'($urandom_range(0, 8191)) - 4096;
        end
        send_record(stim_row_t'{st: st, addr: a, rssi: LEVEL_W'(lvl),
                                stamp: {$urandom, $urandom}, want: WANT_PREDICTED,
                                base: '0, over_edge: '0});
        if (st == STATUS_ACCEPT) count++;
      end
    end
    settle();

    if (pending_alerts.size() != 0) begin
      errors++;
      $display("%0t: %0d alerts expected but never seen", $time, pending_alerts.size());
    end
    $display("Run covered %0d processed and %0d ignored records, %0d alerts checked,",
             processed_records, ignored_records, alerts_seen);
    $display("%0d devices tracked, reset fraction plus %0d written fraction settings.",
             devices_stored, $size(settings));
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rbcd_pkg.sv
sv/rbcd_cell.sv
sv/rbcd_check.sv
sv/rssi_baseline_change_detector.sv
dv/rssi_baseline_change_detector_test.sv
